// ===== src/hsg_pkg.sv =====
`timescale 1ns / 1ps

package hsg_pkg;

   localparam int CFG_W       = 13;
   localparam int CSR_INDEX_W = 1;
   localparam int SAMPLE_W    = 16;
   localparam int DIFF_W      = SAMPLE_W + 1;
   localparam int SLOPE_W     = 29;
   localparam int COORD_W     = 12;
   localparam int REQ_TDATA_W = 16;
   localparam int RSP_TDATA_W = 88;

   // result queue, in whole per-sample bundles
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = 3;

   // result slots of one sample, in delivery order
   localparam int RES_A = 0;   // pixel one row up
   localparam int RES_B = 1;   // previous pixel of the last row
   localparam int RES_C = 2;   // last pixel of the last row
   localparam int RES_N = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_FRAME_WIDTH  = 1'b0,
      REG_FRAME_HEIGHT = 1'b1
   } reg_index_type;

   typedef struct packed {
      logic has_a;      // row above exists
      logic row_gt1;    // bottom neighbor of the upper pixel is the older row
      logic last_row;
      logic col_gt0;
      logic col_gt1;
      logic at_end;     // last column
      logic h_gt1;      // frame has more than one row
   } flags_type;

   typedef struct packed {
      logic signed [SLOPE_W-1:0] slope_x;
      logic signed [SLOPE_W-1:0] slope_y;
      logic [COORD_W-1:0]        col;
      logic [COORD_W-1:0]        row;
      logic                      last;
   } result_type;

   typedef struct packed {
      logic [RES_N-1:0]          mask;
      logic signed [SLOPE_W-1:0] ax;
      logic signed [SLOPE_W-1:0] ay;
      logic signed [SLOPE_W-1:0] bx;
      logic signed [SLOPE_W-1:0] by;
      logic signed [SLOPE_W-1:0] cx;
      logic signed [SLOPE_W-1:0] cy;
      logic [COORD_W-1:0]        col_a;
      logic [COORD_W-1:0]        col_b;
      logic [COORD_W-1:0]        row_a;
      logic [COORD_W-1:0]        row_b;
   } bundle_type;

endpackage

// ===== src/heightmap_slope_gradient.sv =====
`timescale 1ns / 1ps

// channel  direction  handshake              payload
// req      in         req_tvalid/req_tready  req_tdata: height sample
// rsp      out        rsp_tvalid/rsp_tready  rsp_tdata: slopes and pixel position,
//                                            rsp_tlast: last result of a request
// csr      in         csr_we                 csr_index, csr_wdata: frame size
//
// One request per clock while the queue has credit, except on the last row, where a
// request gives up to two results (three on the last pixel) and rsp moves one per clock while rsp_tready is high.
// From request to first result: input register, line store read, multiply, queue,
// output register.
// Reset: synchronous; clears counters and valids, not the line stores (no clearing pass).
// Stalls: req_tready comes from registered queue credit only, never from rsp_tready.
module heightmap_slope_gradient #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                clock,
   input  logic                                reset,
   // req_tdata, from bit 0: height_sample[15:0]
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [hsg_pkg::REQ_TDATA_W-1:0]     req_tdata,
   // rsp_tdata, from bit 0: slope_x_scaled[28:0], slope_y_scaled[28:0],
   // pixel_column[11:0], pixel_row[11:0], zero fill
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [hsg_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic                                rsp_tlast,
   input  logic                                csr_we,
   input  logic [hsg_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hsg_pkg::CFG_W-1:0]           csr_wdata
);
   import hsg_pkg::*;

   // column and row counters, scale factors
   localparam int CW  = (MAX_WIDTH  > 1) ? $clog2(MAX_WIDTH)  : 1;
   localparam int RW  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int SW  = $clog2(MAX_WIDTH + 1);
   localparam int HSW = $clog2(MAX_HEIGHT + 1);
   localparam int PWX = SW + 1 + DIFF_W;
   localparam int PWY = HSW + 1 + DIFF_W;
   localparam int PAD_W = RSP_TDATA_W - (2 * SLOPE_W + 2 * COORD_W);

   function automatic logic [31:0] eff_dim(input logic [CFG_W-1:0] v, input int limit);
      logic [31:0] v32;
      v32 = 32'(v);
      if (v32 == 32'd0) return 32'd1;
      if (v32 > 32'(limit)) return 32'(limit);
      return v32;
   endfunction

   function automatic logic signed [DIFF_W-1:0] sdiff(input logic [SAMPLE_W-1:0] a,
                                                      input logic [SAMPLE_W-1:0] b);
      return $signed({1'b0, a}) - $signed({1'b0, b});
   endfunction

   function automatic logic signed [SLOPE_W-1:0] sat_slope(input logic signed [63:0] p);
      logic signed [63:0] hi;
      logic signed [63:0] lo;
      hi = (64'sd1 <<< (SLOPE_W - 1)) - 64'sd1;
      lo = -(64'sd1 <<< (SLOPE_W - 1));
      if (p > hi) return hi[SLOPE_W-1:0];
      if (p < lo) return lo[SLOPE_W-1:0];
      return p[SLOPE_W-1:0];
   endfunction

   function automatic logic [COORD_W-1:0] fit_coord(input logic [31:0] v);
      return v[COORD_W-1:0];
   endfunction

   // ---------------- configuration ----------------
   logic [CW-1:0]  wlast_ff, wlast_in;
   logic [SW-1:0]  wscale_ff, wscale_in;
   logic [RW-1:0]  hlast_ff, hlast_in;
   logic [HSW-1:0] hscale_ff, hscale_in;
   logic [31:0]    eff_w, eff_h;

   assign eff_w = eff_dim(csr_wdata, MAX_WIDTH);
   assign eff_h = eff_dim(csr_wdata, MAX_HEIGHT);

   always_comb begin
      wlast_in  = wlast_ff;
      wscale_in = wscale_ff;
      hlast_in  = hlast_ff;
      hscale_in = hscale_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_FRAME_WIDTH: begin
               wlast_in  = CW'(eff_w - 32'd1);
               wscale_in = eff_w[SW-1:0];
            end
            REG_FRAME_HEIGHT: begin
               hlast_in  = RW'(eff_h - 32'd1);
               hscale_in = eff_h[HSW-1:0];
            end
            default: ;
         endcase
      end
   end

   // ---------------- raster position ----------------
   logic [CW-1:0] col_cnt_ff, col_cnt_in;
   logic [RW-1:0] row_cnt_ff, row_cnt_in;
   logic          swap_ff, swap_in;
   logic [CW-1:0] col_now;
   logic [RW-1:0] row_now;
   logic          accept;

   assign accept  = req_tvalid && req_tready;
   // counters may sit past a frame size written mid-frame: clamp
   assign col_now = (col_cnt_ff > wlast_ff) ? wlast_ff : col_cnt_ff;
   assign row_now = (row_cnt_ff > hlast_ff) ? hlast_ff : row_cnt_ff;

   always_comb begin
      col_cnt_in = col_cnt_ff;
      row_cnt_in = row_cnt_ff;
      swap_in    = swap_ff;
      if (accept) begin
         if (col_now == wlast_ff) begin
            col_cnt_in = '0;
            if (row_now == hlast_ff) begin
               row_cnt_in = '0;
               swap_in    = 1'b0;
            end else begin
               row_cnt_in = row_now + RW'(1);
               swap_in    = !swap_ff;
            end
         end else begin
            col_cnt_in = col_now + CW'(1);
            row_cnt_in = row_now;
         end
      end
   end

   // ---------------- stage 1: input register ----------------
   logic                s1_valid_ff;
   logic [SAMPLE_W-1:0] s1_sample_ff;
   logic [CW-1:0]       s1_col_ff;
   logic [RW-1:0]       s1_row_ff;
   logic                s1_swap_ff;
   flags_type           s1_flags_ff, s1_flags_in;

   always_comb begin
      s1_flags_in.has_a    = row_now != '0;
      s1_flags_in.row_gt1  = row_now > RW'(1);
      s1_flags_in.last_row = row_now == hlast_ff;
      s1_flags_in.col_gt0  = col_now != '0;
      s1_flags_in.col_gt1  = col_now > CW'(1);
      s1_flags_in.at_end   = col_now == wlast_ff;
      s1_flags_in.h_gt1    = hlast_ff != '0;
   end

   // line store addresses around the current column, clamped to the frame
   logic [CW-1:0] addr_l1, addr_r1, addr_l2;
   logic [CW-1:0] cur_addr [RES_N];
   logic [CW-1:0] mid_addr [RES_N];

   assign addr_l1 = s1_flags_ff.col_gt0 ? s1_col_ff - CW'(1) : '0;
   assign addr_r1 = s1_flags_ff.at_end  ? s1_col_ff : s1_col_ff + CW'(1);
   assign addr_l2 = s1_flags_ff.col_gt1 ? s1_col_ff - CW'(2) : '0;

   // store being overwritten (older row / current row): col, col-1, col-2
   assign cur_addr[0] = s1_col_ff;
   assign cur_addr[1] = addr_l1;
   assign cur_addr[2] = addr_l2;
   // previous row: col-1, col+1, col
   assign mid_addr[0] = addr_l1;
   assign mid_addr[1] = addr_r1;
   assign mid_addr[2] = s1_col_ff;

   // two physical line stores, three read copies each
   logic [SAMPLE_W-1:0] rd_word [2][RES_N];

   for (genvar k = 0; k < 2; k++) begin : g_store
      logic st_we;
      assign st_we = s1_valid_ff && (s1_swap_ff == 1'(k));
      for (genvar j = 0; j < RES_N; j++) begin : g_copy
         hsg_ram #(
            .DEPTH (MAX_WIDTH),
            .AW    (CW),
            .DW    (SAMPLE_W)
         ) u_ram (
            .clock   (clock),
            .wr_en   (st_we),
            .wr_addr (s1_col_ff),
            .wr_data (s1_sample_ff),
            .rd_addr ((s1_swap_ff == 1'(k)) ? cur_addr[j] : mid_addr[j]),
            .rd_data (rd_word[k][j])
         );
      end
   end

   // ---------------- stage 2: store data, differences ----------------
   logic                s2_valid_ff;
   logic [SAMPLE_W-1:0] s2_sample_ff;
   logic [CW-1:0]       s2_col_ff;
   logic [RW-1:0]       s2_row_ff;
   logic                s2_swap_ff;
   flags_type           s2_flags_ff;

   logic [SAMPLE_W-1:0] cur_d [RES_N];
   logic [SAMPLE_W-1:0] mid_d [RES_N];
   logic [SAMPLE_W-1:0] a_bot, b_self, b_bot, c_left, c_bot;
   logic signed [DIFF_W-1:0] dx [RES_N];
   logic signed [DIFF_W-1:0] dy [RES_N];
   logic [RES_N-1:0]    s2_mask;

   always_comb begin
      for (int j = 0; j < RES_N; j++) begin
         cur_d[j] = s2_swap_ff ? rd_word[1][j] : rd_word[0][j];
         mid_d[j] = s2_swap_ff ? rd_word[0][j] : rd_word[1][j];
      end
   end

   // upper pixel: bottom neighbor is the older row, or itself on row one
   assign a_bot  = s2_flags_ff.row_gt1 ? cur_d[0] : mid_d[2];
   assign b_self = cur_d[1];
   assign b_bot  = s2_flags_ff.h_gt1 ? mid_d[0] : b_self;
   assign c_left = s2_flags_ff.col_gt0 ? cur_d[1] : s2_sample_ff;
   assign c_bot  = s2_flags_ff.h_gt1 ? mid_d[2] : s2_sample_ff;

   always_comb begin
      dx[RES_A] = sdiff(mid_d[1], mid_d[0]);
      dy[RES_A] = sdiff(s2_sample_ff, a_bot);
      dx[RES_B] = sdiff(s2_sample_ff, cur_d[2]);
      dy[RES_B] = sdiff(b_self, b_bot);
      dx[RES_C] = sdiff(s2_sample_ff, c_left);
      dy[RES_C] = sdiff(s2_sample_ff, c_bot);
   end

   assign s2_mask[RES_A] = s2_flags_ff.has_a;
   assign s2_mask[RES_B] = s2_flags_ff.last_row && s2_flags_ff.col_gt0;
   assign s2_mask[RES_C] = s2_flags_ff.last_row && s2_flags_ff.at_end;

   // ---------------- stage 3: products ----------------
   logic                  s3_valid_ff;
   logic [RES_N-1:0]      s3_mask_ff;
   logic [CW-1:0]         s3_col_ff;
   logic [RW-1:0]         s3_row_ff;
   logic signed [PWX-1:0] s3_px_ff [RES_N];
   logic signed [PWY-1:0] s3_py_ff [RES_N];
   logic signed [PWX-1:0] s3_px_in [RES_N];
   logic signed [PWY-1:0] s3_py_in [RES_N];

   always_comb begin
      for (int j = 0; j < RES_N; j++) begin
         s3_px_in[j] = $signed({1'b0, wscale_ff}) * dx[j];
         s3_py_in[j] = $signed({1'b0, hscale_ff}) * dy[j];
      end
   end

   // ---------------- saturate, push into the result queue ----------------
   logic            push_valid;
   bundle_type      push_bundle;
   logic [QPTR_W:0] q_count;
   result_type      rsp_result;

   assign push_valid = s3_valid_ff && (s3_mask_ff != '0);

   always_comb begin
      push_bundle.mask  = s3_mask_ff;
      push_bundle.ax    = sat_slope(64'(s3_px_ff[RES_A]));
      push_bundle.ay    = sat_slope(64'(s3_py_ff[RES_A]));
      push_bundle.bx    = sat_slope(64'(s3_px_ff[RES_B]));
      push_bundle.by    = sat_slope(64'(s3_py_ff[RES_B]));
      push_bundle.cx    = sat_slope(64'(s3_px_ff[RES_C]));
      push_bundle.cy    = sat_slope(64'(s3_py_ff[RES_C]));
      push_bundle.col_a = fit_coord(32'(s3_col_ff));
      push_bundle.col_b = fit_coord(32'(s3_col_ff) - 32'd1);
      push_bundle.row_a = fit_coord(32'(s3_row_ff) - 32'd1);
      push_bundle.row_b = fit_coord(32'(s3_row_ff));
   end

   hsg_rsp_queue u_queue (
      .clock       (clock),
      .reset       (reset),
      .push_valid  (push_valid),
      .push_bundle (push_bundle),
      .count       (q_count),
      .rsp_valid   (rsp_tvalid),
      .rsp_ready   (rsp_tready),
      .rsp_result  (rsp_result)
   );

   // credit: everything in flight must fit in the queue
   logic [QPTR_W+1:0] pending;

   assign pending = (QPTR_W+2)'(q_count) + (QPTR_W+2)'(s1_valid_ff)
                  + (QPTR_W+2)'(s2_valid_ff) + (QPTR_W+2)'(s3_valid_ff);
   assign req_tready = pending < (QPTR_W+2)'(QUEUE_DEPTH);

   assign rsp_tdata = {PAD_W'(0), rsp_result.row, rsp_result.col,
                       rsp_result.slope_y, rsp_result.slope_x};
   assign rsp_tlast = rsp_result.last;

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         wlast_ff    <= '0;
         wscale_ff   <= SW'(1);
         hlast_ff    <= '0;
         hscale_ff   <= HSW'(1);
         col_cnt_ff  <= '0;
         row_cnt_ff  <= '0;
         swap_ff     <= 1'b0;
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         wlast_ff    <= wlast_in;
         wscale_ff   <= wscale_in;
         hlast_ff    <= hlast_in;
         hscale_ff   <= hscale_in;
         col_cnt_ff  <= col_cnt_in;
         row_cnt_ff  <= row_cnt_in;
         swap_ff     <= swap_in;
         s1_valid_ff <= accept;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // payload, free running behind the valids
   always_ff @(posedge clock) begin
      s1_sample_ff <= req_tdata[SAMPLE_W-1:0];
      s1_col_ff    <= col_now;
      s1_row_ff    <= row_now;
      s1_swap_ff   <= swap_ff;
      s1_flags_ff  <= s1_flags_in;
      s2_sample_ff <= s1_sample_ff;
      s2_col_ff    <= s1_col_ff;
      s2_row_ff    <= s1_row_ff;
      s2_swap_ff   <= s1_swap_ff;
      s2_flags_ff  <= s1_flags_ff;
      s3_mask_ff   <= s2_mask;
      s3_col_ff    <= s2_col_ff;
      s3_row_ff    <= s2_row_ff;
      for (int j = 0; j < RES_N; j++) begin
         s3_px_ff[j] <= s3_px_in[j];
         s3_py_ff[j] <= s3_py_in[j];
      end
   end

endmodule

// ===== src/hsg_ram.sv =====
`timescale 1ns / 1ps

// one write port, one read port, registered read, read-before-write
module hsg_ram #(
   parameter int DEPTH = 4096,
   parameter int AW    = 12,
   parameter int DW    = 16
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data
);

   logic [DW-1:0] mem_ff [DEPTH];
   logic [DW-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/hsg_rsp_queue.sv =====
`timescale 1ns / 1ps

// queue of per-sample result bundles; unrolls each bundle into single
// results through an output register
module hsg_rsp_queue (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          push_valid,
   input  hsg_pkg::bundle_type           push_bundle,
   output logic [hsg_pkg::QPTR_W:0]      count,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output hsg_pkg::result_type           rsp_result
);
   import hsg_pkg::*;

   bundle_type       mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic [RES_N-1:0]  done_ff, done_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_result_ff, rsp_result_in;

   bundle_type        head;
   logic [RES_N-1:0]  pend;
   logic [RES_N-1:0]  sel;
   logic              is_last;
   logic              load;
   logic              pop;

   assign head = mem_ff[rd_ptr_ff];
   assign pend = head.mask & ~done_ff;

   always_comb begin
      sel = '0;
      priority if (pend[RES_A]) begin
         sel[RES_A] = 1'b1;
      end else if (pend[RES_B]) begin
         sel[RES_B] = 1'b1;
      end else begin
         sel[RES_C] = 1'b1;
      end
   end

   assign is_last = (pend & ~sel) == '0;
   assign load    = (count_ff != '0) && (!rsp_valid_ff || rsp_ready);
   assign pop     = load && is_last;

   always_comb begin
      rsp_result_in = rsp_result_ff;
      if (load) begin
         priority if (sel[RES_A]) begin
            rsp_result_in.slope_x = head.ax;
            rsp_result_in.slope_y = head.ay;
            rsp_result_in.col     = head.col_a;
            rsp_result_in.row     = head.row_a;
         end else if (sel[RES_B]) begin
            rsp_result_in.slope_x = head.bx;
            rsp_result_in.slope_y = head.by;
            rsp_result_in.col     = head.col_b;
            rsp_result_in.row     = head.row_b;
         end else begin
            rsp_result_in.slope_x = head.cx;
            rsp_result_in.slope_y = head.cy;
            rsp_result_in.col     = head.col_a;
            rsp_result_in.row     = head.row_b;
         end
         rsp_result_in.last = is_last;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      done_in   = load ? (is_last ? '0 : (done_ff | sel)) : done_ff;
      wr_ptr_in = push_valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff + (QPTR_W+1)'(push_valid) - (QPTR_W+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         count_ff     <= '0;
         done_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wr_ptr_ff    <= wr_ptr_in;
         rd_ptr_ff    <= rd_ptr_in;
         count_ff     <= count_in;
         done_ff      <= done_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         mem_ff[wr_ptr_ff] <= push_bundle;
      end
      rsp_result_ff <= rsp_result_in;
   end

   assign count      = count_ff;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_result = rsp_result_ff;

endmodule

// ===== src/hsg_checker.sv =====
`timescale 1ns / 1ps

module hsg_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [hsg_pkg::RSP_TDATA_W-1:0] rsp_tdata,
   input logic                            rsp_tlast
);

   // coming out of reset: nothing to send, room for a request
   a_reset_state: assert property (@(posedge clock)
      reset |=> (!rsp_tvalid && req_tready))
      else $error("rsp valid or req not ready right after reset");

   // a run of results from one request comes out without gaps
   a_run_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=> rsp_tvalid)
      else $error("gap inside a run of results");

   a_rsp_hold_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid)
      else $error("rsp valid dropped while stalled");

   a_rsp_hold_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> ($stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("rsp payload changed while stalled");

endmodule

bind heightmap_slope_gradient hsg_checker u_hsg_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
